// ----- sv/esf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esf_pkg
// Types and constants shared by the ellipse span fill block.
// ----------------------------------------------------------------------------
package esf_pkg;

    localparam int CoordW = 12;   // box origin
    localparam int WidthW = 7;    // box width
    localparam int HeightW = 10;  // box height
    localparam int OutW = 13;     // emitted columns and rows
    localparam int ColW = 6;      // column index within the left half
    localparam int WalkW = 12;    // doubled walk row, two's complement
    localparam int ProdW = 17;    // |offset| * extent
    localparam int SqW = 34;      // squared products

    typedef struct packed {
        logic [CoordW-1:0]  origin_x;
        logic [CoordW-1:0]  origin_y;
        logic [WidthW-1:0]  box_width;
        logic [HeightW-1:0] box_height;
        logic               inverted;
    } t_in_item;

    typedef struct packed {
        logic [OutW-1:0] left_x;
        logic [OutW-1:0] right_x;
        logic [OutW-1:0] seg_a_from;
        logic [OutW-1:0] seg_a_to;
        logic            seg_b_valid;
        logic [OutW-1:0] seg_b_from;
        logic [OutW-1:0] seg_b_to;
        logic            last;
    } t_out_item;

    // Classified box command, as queued between front and back.
    typedef struct packed {
        logic [CoordW-1:0]  bx;
        logic [CoordW-1:0]  by;
        logic [WidthW-1:0]  w;
        logic [HeightW-1:0] h;
        logic               inv;
        logic [ColW-1:0]    last_col;   // w/2
        logic [OutW-1:0]    by_plus_h;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIM,
        S_COL,
        S_XSQ,
        S_STEP,
        S_SQ,
        S_CMP,
        S_EMIT
    } t_back_state;

endpackage
`default_nettype wire

// ----- sv/esf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esf_front
// Input stage: takes a box, derives its last column index and box bottom,
// and hands the command to the queue.
// ----------------------------------------------------------------------------
module esf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire esf_pkg::t_in_item i_in_data,
    output logic                   o_push,
    output esf_pkg::t_cmd          o_cmd,
    input  wire logic              i_full
);

    logic          r_valid;
    esf_pkg::t_cmd r_cmd;
    esf_pkg::t_cmd n_cmd;
    logic          w_take;

    assign o_push     = r_valid && !i_full;
    assign o_in_ready = !r_valid || !i_full;
    assign w_take     = i_in_valid && o_in_ready;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.bx        = i_in_data.origin_x;
        n_cmd.by        = i_in_data.origin_y;
        n_cmd.w         = i_in_data.box_width;
        n_cmd.h         = i_in_data.box_height;
        n_cmd.inv       = i_in_data.inverted;
        n_cmd.last_col  = i_in_data.box_width[esf_pkg::WidthW-1:1];
        n_cmd.by_plus_h = {1'b0, i_in_data.origin_y}
                        + {{(esf_pkg::OutW-esf_pkg::HeightW){1'b0}}, i_in_data.box_height};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- sv/esf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esf_queue
// Two-entry command queue between the front and the walker.
// ----------------------------------------------------------------------------
module esf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire esf_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output esf_pkg::t_cmd      o_cmd
);

    esf_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- sv/esf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esf_back
// Column walker: per column, squares the x term, then walks the top row up
// one doubled step at a time while the pixel center stays inside the
// ellipse, and loads the result register.
// ----------------------------------------------------------------------------
module esf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire esf_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output esf_pkg::t_out_item o_out_data
);

    localparam int OW = esf_pkg::OutW;
    localparam int WW = esf_pkg::WalkW;

    esf_pkg::t_back_state r_state, n_state;
    esf_pkg::t_cmd        r_cmd, n_cmd;
    logic [esf_pkg::ProdW-1:0] r_wh, n_wh;
    logic [esf_pkg::SqW-1:0]   r_lim, n_lim;
    logic [esf_pkg::ProdW-1:0] r_p, n_p;
    logic [esf_pkg::SqW-1:0]   r_xterm, n_xterm;
    logic [esf_pkg::ProdW-1:0] r_q, n_q;
    logic [esf_pkg::SqW-1:0]   r_sq, n_sq;
    logic signed [WW-1:0]      r_r, n_r;
    logic [esf_pkg::ColW-1:0]  r_i, n_i;
    logic                      r_out_valid, n_out_valid;
    esf_pkg::t_out_item        r_out, n_out;

    // column offset
    logic [7:0]               w_odd;
    logic [8:0]               w_dx;
    logic [8:0]               w_dx_neg;
    logic [esf_pkg::WidthW-1:0] w_dx_abs;
    // walk candidate
    logic signed [WW-1:0]     w_cand;
    logic signed [WW-1:0]     w_dy;
    logic signed [WW-1:0]     w_dy_neg;
    logic [WW-2:0]            w_dy_abs;
    logic [esf_pkg::SqW:0]    w_sum;
    // result rows
    logic [WW-1:0]            w_rp2;
    logic [13:0]              w_top;
    logic [OW-1:0]            w_dbl;
    logic [OW-1:0]            w_bottom;
    logic [OW-1:0]            w_top_row;
    logic                     w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_odd    = {1'b0, r_i, 1'b1};
        w_dx     = {1'b0, w_odd} - {2'b0, r_cmd.w};
        w_dx_neg = 9'd0 - w_dx;
        w_dx_abs = w_dx[8] ? w_dx_neg[6:0] : w_dx[6:0];

        w_cand   = r_r - 12'sd2;
        w_dy     = w_cand + 12'sd1 - $signed({2'b0, r_cmd.h});
        w_dy_neg = 12'sd0 - w_dy;
        w_dy_abs = w_dy[WW-1] ? w_dy_neg[WW-2:0] : w_dy[WW-2:0];
        w_sum    = {1'b0, r_xterm} + {1'b0, r_sq};

        // top = by + (r+2)/2 - 1, clamped at zero; r never drops below -2
        w_rp2     = r_r + 12'sd2;
        w_top     = {2'b0, r_cmd.by} + {3'b0, w_rp2[WW-1:1]} - 14'd1;
        w_top_row = w_top[13] ? '0 : w_top[OW-1:0];
        // bottom = by + (2h - r)/2
        w_dbl     = {2'b0, r_cmd.h, 1'b0} - {r_r[WW-1], r_r};
        w_bottom  = {1'b0, r_cmd.by} + {1'b0, w_dbl[OW-1:1]};
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_wh        = r_wh;
        n_lim       = r_lim;
        n_p         = r_p;
        n_xterm     = r_xterm;
        n_q         = r_q;
        n_sq        = r_sq;
        n_r         = r_r;
        n_i         = r_i;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;

        case (r_state)
            esf_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_wh    = esf_pkg::ProdW'(i_cmd.w * i_cmd.h);
                    n_r     = $signed({2'b0, i_cmd.h});
                    n_i     = '0;
                    n_state = esf_pkg::S_LIM;
                end
            end
            esf_pkg::S_LIM: begin
                n_lim   = esf_pkg::SqW'(r_wh * r_wh);
                n_state = esf_pkg::S_COL;
            end
            esf_pkg::S_COL: begin
                n_p     = esf_pkg::ProdW'(w_dx_abs * r_cmd.h);
                n_state = esf_pkg::S_XSQ;
            end
            esf_pkg::S_XSQ: begin
                n_xterm = esf_pkg::SqW'(r_p * r_p);
                n_state = esf_pkg::S_STEP;
            end
            esf_pkg::S_STEP: begin
                // walk stops one row above the box
                if (w_cand < -12'sd2) begin
                    n_state = esf_pkg::S_EMIT;
                end else begin
                    n_q     = esf_pkg::ProdW'(w_dy_abs * r_cmd.w);
                    n_state = esf_pkg::S_SQ;
                end
            end
            esf_pkg::S_SQ: begin
                n_sq    = esf_pkg::SqW'(r_q * r_q);
                n_state = esf_pkg::S_CMP;
            end
            esf_pkg::S_CMP: begin
                if (w_sum > {1'b0, r_lim}) begin
                    n_state = esf_pkg::S_EMIT;
                end else begin
                    n_r     = w_cand;
                    n_state = esf_pkg::S_STEP;
                end
            end
            esf_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.left_x     = {1'b0, r_cmd.bx} + {7'b0, r_i};
                    n_out.right_x    = {1'b0, r_cmd.bx} + {6'b0, r_cmd.w} - {7'b0, r_i};
                    n_out.seg_a_from = w_top_row;
                    n_out.seg_a_to   = r_cmd.inv ? {1'b0, r_cmd.by} : w_bottom;
                    n_out.seg_b_valid = r_cmd.inv;
                    n_out.seg_b_from = r_cmd.inv ? w_bottom : '0;
                    n_out.seg_b_to   = r_cmd.inv ? r_cmd.by_plus_h : '0;
                    n_out.last       = (r_i == r_cmd.last_col);
                    if (r_i == r_cmd.last_col) begin
                        n_state = esf_pkg::S_IDLE;
                    end else begin
                        n_i     = r_i + esf_pkg::ColW'(1);
                        n_state = esf_pkg::S_COL;
                    end
                end
            end
            default: begin
                n_state = esf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_r         <= '0;
            r_i         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_r         <= n_r;
            r_i         <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_wh    <= n_wh;
        r_lim   <= n_lim;
        r_p     <= n_p;
        r_xterm <= n_xterm;
        r_q     <= n_q;
        r_sq    <= n_sq;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire

// ----- sv/ellipse_span_fill.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_span_fill
// Scanline fill of the ellipse inscribed in a box, one result per column of
// the left half, each naming the column and its mirror.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one box per
//   transfer. Output channel (o_out_valid / i_out_ready / o_out_data) gives
//   box_width/2+1 transfers per box, the final one flagged by last.
//   A box is registered by the front stage and waits in a two-entry queue,
//   so up to three boxes can be taken while the walker is busy.
//   Walker per box: set up (S_IDLE, S_LIM), then per column the x term and
//   result (S_COL, S_XSQ, S_EMIT), plus S_STEP, S_SQ and S_CMP per test of
//   the walk; the walk only moves upward across the columns of a box,
//   through the shared multiply-square-compare loop.
//   A stalled receiver holds the result register; the walker keeps working
//   on the next column and waits only when it has a second result ready.
//   Synchronous active-low reset empties the queue and drops any result.
// ----------------------------------------------------------------------------
module ellipse_span_fill (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire esf_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output esf_pkg::t_out_item      o_out_data
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    esf_pkg::t_cmd w_front_cmd;
    esf_pkg::t_cmd w_q_cmd;

    esf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd),
        .i_full     (w_full)
    );

    esf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    esf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
